[src/three_stop_color_gradient_top_assert.svh]
// Assertion macros shared by the color gradient RTL.
`ifndef THREE_STOP_COLOR_GRADIENT_TOP_ASSERT_SVH
`define THREE_STOP_COLOR_GRADIENT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSCG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSCG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tscg_pkg.sv]
// Shared types, constants and helper functions of the color gradient.
`timescale 1ns / 1ps
`default_nettype none
package tscg_pkg;

    localparam int SampleW  = 16;
    localparam int ColorW   = 24;
    localparam int ChanW    = 8;
    localparam int NumChan  = 3;
    localparam int LevelW   = 8;
    localparam int DivW     = 16;
    localparam int RemW     = 24;
    localparam int SumW     = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int NumCells = LevelW;

    localparam logic [ColorW-1:0]  ColorReset = 24'hFFFFFF;
    localparam logic [SampleW-1:0] ThrReset   = 16'h0000;
    localparam logic [ChanW-1:0]   FullLevel  = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LOW_COLOR  = 3'd0,
        CFG_MID_COLOR  = 3'd1,
        CFG_HIGH_COLOR = 3'd2,
        CFG_LOW_THR    = 3'd3,
        CFG_MID_THR    = 3'd4,
        CFG_HIGH_THR   = 3'd5
    } t_cfg_idx;

    // What the result color is made of.
    typedef enum logic [2:0] {
        PICK_LOW,
        PICK_MID,
        PICK_HIGH,
        PICK_BLEND_LO,
        PICK_BLEND_HI
    } t_pick;

    typedef struct packed {
        logic [ColorW-1:0]         low_color;
        logic [ColorW-1:0]         mid_color;
        logic [ColorW-1:0]         high_color;
        logic signed [SampleW-1:0] low_thr;
        logic signed [SampleW-1:0] mid_thr;
        logic signed [SampleW-1:0] high_thr;
    } t_cfg;

    // Word handed from cell to cell of the level divider.
    typedef struct packed {
        t_pick             pick;
        logic [RemW-1:0]   rem;
        logic [DivW-1:0]   div;
        logic [LevelW-1:0] quo;
    } t_div;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [ChanW-1:0] div255(input logic [SumW-1:0] x);
        logic [SumW:0] s;
        s = {1'b0, x} + {{(SumW-ChanW+1){1'b0}}, x[SumW-1:ChanW]} + 17'd1;
        return s[SumW-1:ChanW];
    endfunction

endpackage
`default_nettype wire

[src/tscg_if.sv]
// Handshake interfaces of the color gradient: sample, color and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface tscg_sample_if import tscg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample;
    logic                      mode;
    modport source (output valid, sample, mode, input ready);
    modport sink (input valid, sample, mode, output ready);
endinterface

interface tscg_color_if import tscg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface tscg_cfg_if import tscg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/tscg_front.sv]
// Front stage: classifies the sample against the stops and sets up the division.
`timescale 1ns / 1ps
`default_nettype none
module tscg_front import tscg_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_cfg                     i_cfg,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire signed [SampleW-1:0] i_sample,
    input  wire                      i_mode,
    output logic                     o_valid,
    input  wire                      i_ready,
    output t_div                     o_data
);

    logic              r_valid;
    t_div              r_data;
    t_div              n_data;
    t_pick             w_pick;
    logic [SampleW:0]  w_off_lo;
    logic [SampleW:0]  w_off_mid;
    logic [SampleW:0]  w_wid_lo;
    logic [SampleW:0]  w_wid_hi;
    logic [DivW-1:0]   w_t;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Stop tests, made in order of priority.
    always_comb begin
        priority if (i_sample <= i_cfg.low_thr) begin
            w_pick = PICK_LOW;
        end else if (i_sample < i_cfg.mid_thr) begin
            w_pick = i_mode ? PICK_LOW : PICK_BLEND_LO;
        end else if (i_sample == i_cfg.mid_thr) begin
            w_pick = PICK_MID;
        end else if (i_sample < i_cfg.high_thr) begin
            w_pick = i_mode ? PICK_MID : PICK_BLEND_HI;
        end else begin
            w_pick = PICK_HIGH;
        end
    end

    // Offset into the segment and segment width; both are positive inside a segment.
    assign w_off_lo  = {i_sample[SampleW-1], i_sample}
                     - {i_cfg.low_thr[SampleW-1], i_cfg.low_thr};
    assign w_off_mid = {i_sample[SampleW-1], i_sample}
                     - {i_cfg.mid_thr[SampleW-1], i_cfg.mid_thr};
    assign w_wid_lo  = {i_cfg.mid_thr[SampleW-1], i_cfg.mid_thr}
                     - {i_cfg.low_thr[SampleW-1], i_cfg.low_thr};
    assign w_wid_hi  = {i_cfg.high_thr[SampleW-1], i_cfg.high_thr}
                     - {i_cfg.mid_thr[SampleW-1], i_cfg.mid_thr};

    // Dividend is 255 times the offset; the divider turns it into the level.
    always_comb begin
        n_data      = '0;
        n_data.pick = w_pick;
        if (w_pick == PICK_BLEND_HI) begin
            w_t        = w_off_mid[DivW-1:0];
            n_data.div = w_wid_hi[DivW-1:0];
        end else begin
            w_t        = w_off_lo[DivW-1:0];
            n_data.div = w_wid_lo[DivW-1:0];
        end
        if (w_pick == PICK_BLEND_LO || w_pick == PICK_BLEND_HI) begin
            n_data.rem = {w_t, {(RemW-DivW){1'b0}}} - {{(RemW-DivW){1'b0}}, w_t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

[src/tscg_div_cell.sv]
// One cell of the level divider: settles one quotient bit per transfer.
`timescale 1ns / 1ps
`default_nettype none
module tscg_div_cell import tscg_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_div  i_data,
    output logic  o_valid,
    input  wire   i_ready,
    output t_div  o_data
);

    localparam int LowPad = LevelW - 1;

    logic            r_valid;
    t_div            r_data;
    t_div            n_data;
    logic [RemW-1:0] w_dd;
    logic            w_ge;
    logic [RemW-1:0] w_rem;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Divisor aligned to the top quotient bit; the remainder shifts up each cell.
    assign w_dd  = {1'b0, i_data.div, {LowPad{1'b0}}};
    assign w_ge  = i_data.rem >= w_dd;
    assign w_rem = w_ge ? i_data.rem - w_dd : i_data.rem;

    always_comb begin
        n_data     = i_data;
        n_data.rem = {w_rem[RemW-2:0], 1'b0};
        n_data.quo = {i_data.quo[LevelW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

[src/tscg_blend.sv]
// Blend stages: weighted channel sums, then division by 255 or the plain stop color into the output register.
`timescale 1ns / 1ps
`default_nettype none
module tscg_blend import tscg_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cfg              i_cfg,
    input  wire               i_valid,
    output logic              o_ready,
    input  t_div              i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [ChanW-1:0]  o_red,
    output logic [ChanW-1:0]  o_green,
    output logic [ChanW-1:0]  o_blue
);

    typedef struct packed {
        logic                          blend;
        logic [ColorW-1:0]             color;
        logic [NumChan-1:0][SumW-1:0]  sum;
    } t_mix;

    logic               r_mix_valid;
    t_mix               r_mix;
    t_mix               n_mix;
    logic               w_mix_ready;
    logic               r_out_valid;
    logic [ColorW-1:0]  r_out;
    logic [ColorW-1:0]  n_out;
    logic [ColorW-1:0]  w_c0;
    logic [ColorW-1:0]  w_c1;
    logic [ChanW-1:0]   w_inv;

    assign w_mix_ready = !r_out_valid || i_ready;
    assign o_ready     = !r_mix_valid || w_mix_ready;
    assign o_valid     = r_out_valid;
    assign o_red       = r_out[3*ChanW-1:2*ChanW];
    assign o_green     = r_out[2*ChanW-1:ChanW];
    assign o_blue      = r_out[ChanW-1:0];

    // Weight of the lower end color.
    assign w_inv = FullLevel - i_data.quo;

    // Select the end colors of the segment, or the plain stop color.
    always_comb begin
        w_c0        = '0;
        w_c1        = '0;
        n_mix.blend = 1'b0;
        n_mix.color = '0;
        unique case (i_data.pick)
            PICK_LOW:      n_mix.color = i_cfg.low_color;
            PICK_MID:      n_mix.color = i_cfg.mid_color;
            PICK_HIGH:     n_mix.color = i_cfg.high_color;
            PICK_BLEND_LO: begin
                n_mix.blend = 1'b1;
                w_c0        = i_cfg.low_color;
                w_c1        = i_cfg.mid_color;
            end
            PICK_BLEND_HI: begin
                n_mix.blend = 1'b1;
                w_c0        = i_cfg.mid_color;
                w_c1        = i_cfg.high_color;
            end
            default:       n_mix.color = '0;
        endcase
        // Weighted sum per channel: c0 * (255 - level) + c1 * level.
        for (int k = 0; k < NumChan; k++) begin
            n_mix.sum[k] = SumW'(SumW'(w_c0[k*ChanW +: ChanW]) * SumW'(w_inv))
                         + SumW'(SumW'(w_c1[k*ChanW +: ChanW]) * SumW'(i_data.quo));
        end
    end

    // Divide each sum by 255 or pass the stop color.
    always_comb begin
        n_out = r_mix.color;
        if (r_mix.blend) begin
            for (int k = 0; k < NumChan; k++) begin
                n_out[k*ChanW +: ChanW] = div255(r_mix.sum[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_mix_valid <= i_valid;
            end
            if (w_mix_ready) begin
                r_out_valid <= r_mix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mix <= n_mix;
        end
        if (w_mix_ready && r_mix_valid) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

[src/three_stop_color_gradient_top.sv]
// Top level of the three-stop color gradient.
//
// Usage: the sample channel carries a signed 16-bit sample and a mode bit
// (0 blends between stops, 1 gives the color of the lower stop). The color
// channel returns one red, green and blue triple for every sample, in order.
// The configuration channel writes the stop colors and thresholds by index;
// it is always ready and should only be used while no sample is in flight.
// Pipeline: one classify stage, eight divider cells that each settle one bit
// of the blend level, one weighted-sum stage and the output register.
// Throughput: one sample per cycle while the receiver keeps ready high, set
// by the divider chain, which holds a different sample in every cell.
// Reset: all stage valid flags clear, the colors return to white and the
// thresholds to zero. Samples are taken as soon as reset is released.
// Stall: when the receiver holds ready low, the result waits in the output
// register and earlier stages keep filling bubbles; sample ready drops only
// once all eleven stages hold a sample.
`timescale 1ns / 1ps
`default_nettype none
module three_stop_color_gradient_top import tscg_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    tscg_sample_if.sink       i_sample,
    tscg_cfg_if.sink          i_cfg,
    tscg_color_if.source      o_color
);

    t_cfg r_cfg;
    t_div w_cell_data  [NumCells+1];
    logic w_cell_valid [NumCells+1];
    logic w_cell_ready [NumCells+1];

    // Configuration registers; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_color  <= ColorReset;
            r_cfg.mid_color  <= ColorReset;
            r_cfg.high_color <= ColorReset;
            r_cfg.low_thr    <= ThrReset;
            r_cfg.mid_thr    <= ThrReset;
            r_cfg.high_thr   <= ThrReset;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_LOW_COLOR:  r_cfg.low_color  <= i_cfg.data[ColorW-1:0];
                CFG_MID_COLOR:  r_cfg.mid_color  <= i_cfg.data[ColorW-1:0];
                CFG_HIGH_COLOR: r_cfg.high_color <= i_cfg.data[ColorW-1:0];
                CFG_LOW_THR:    r_cfg.low_thr    <= i_cfg.data[SampleW-1:0];
                CFG_MID_THR:    r_cfg.mid_thr    <= i_cfg.data[SampleW-1:0];
                CFG_HIGH_THR:   r_cfg.high_thr   <= i_cfg.data[SampleW-1:0];
                default:        r_cfg.low_thr    <= r_cfg.low_thr;
            endcase
        end
    end

    // Classify stage.
    tscg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_sample.valid),
        .o_ready  (i_sample.ready),
        .i_sample (i_sample.sample),
        .i_mode   (i_sample.mode),
        .o_valid  (w_cell_valid[0]),
        .i_ready  (w_cell_ready[0]),
        .o_data   (w_cell_data[0])
    );

    // Divider chain, one quotient bit per cell, most significant first.
    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        tscg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cell_valid[g]),
            .o_ready (w_cell_ready[g]),
            .i_data  (w_cell_data[g]),
            .o_valid (w_cell_valid[g+1]),
            .i_ready (w_cell_ready[g+1]),
            .o_data  (w_cell_data[g+1])
        );
    end

    // Weighted sums and output register.
    tscg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_cell_valid[NumCells]),
        .o_ready (w_cell_ready[NumCells]),
        .i_data  (w_cell_data[NumCells]),
        .o_valid (o_color.valid),
        .i_ready (o_color.ready),
        .o_red   (o_color.red),
        .o_green (o_color.green),
        .o_blue  (o_color.blue)
    );

`include "three_stop_color_gradient_top_assert.svh"

    // An empty output register means every stage can move, so a sample can be taken.
    `TSCG_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, !o_color.valid, i_sample.ready,
        "sample not ready while output register is empty")

    // A blended segment always has a nonzero width.
    `TSCG_ASSERT_IMP(a_blend_width, i_clk, i_rst_n,
        w_cell_valid[0] && (w_cell_data[0].pick == PICK_BLEND_LO
                         || w_cell_data[0].pick == PICK_BLEND_HI),
        w_cell_data[0].div != '0, "blend segment with zero width")

    // The dividend stays below 256 times the divisor, so the level fits eight bits.
    `TSCG_ASSERT_IMP(a_div_bound, i_clk, i_rst_n,
        w_cell_valid[0] && (w_cell_data[0].pick == PICK_BLEND_LO
                         || w_cell_data[0].pick == PICK_BLEND_HI),
        w_cell_data[0].rem < {w_cell_data[0].div, {(RemW-DivW){1'b0}}},
        "divider input out of range")

    // A blend level never reaches full scale.
    `TSCG_ASSERT_IMP(a_level_range, i_clk, i_rst_n,
        w_cell_valid[NumCells] && (w_cell_data[NumCells].pick == PICK_BLEND_LO
                                || w_cell_data[NumCells].pick == PICK_BLEND_HI),
        w_cell_data[NumCells].quo != FullLevel, "blend level at full scale")

endmodule
`default_nettype wire
